>>> src/plvd_pkg.sv
package plvd_pkg;

    localparam int unsigned MAX_VALUE_BYTES = 8;

    localparam logic [7:0] PREFIX_BYTE = 8'hff;
    localparam logic [6:0] SIGNED_PREFIX_BITS = 7'h7f;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PREFIX  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  length_count;
        logic [63:0] accumulator;
        logic        sign_flag;
    } dec_state_t;

    typedef struct packed {
        logic        emit;
        logic        status;
        logic [63:0] value;
    } dec_result_t;

    // leading ones of a byte, counted from bit 7 down
    function automatic logic [3:0] lead_ones8(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int k = 7; k >= 0; k--)
        begin
            run = run & b[k];
            n   = n + {3'b000, run};
        end
        return n;
    endfunction

    // leading ones of the low seven bits, counted from bit 6 down
    function automatic logic [3:0] lead_ones7(input logic [6:0] b);
        logic [3:0] n;
        logic       run;
        n   = 4'd0;
        run = 1'b1;
        for (int k = 6; k >= 0; k--)
        begin
            run = run & b[k];
            n   = n + {3'b000, run};
        end
        return n;
    endfunction

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [3:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {5'b00000, b};
        return s[8] ? 8'hff : s[7:0];
    endfunction

endpackage

>>> src/prefix_length_varint_decoder.sv
// an accepted byte is registered in the input stage, and its step result is registered in the output stage
// one byte per cycle while in_stall is low; a byte that completes no value yields nothing
// the decode step is a leading-ones count, a byte shift-in and a 64-bit negate
// reset (rst_n low, asynchronous) empties both stages and returns to idle
// signed_mode resets to unsigned decode
module prefix_length_varint_decoder
    import plvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic        status
);

    logic        signed_mode_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_res;
    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic        status_reg;
    logic        s1_take;
    logic        in_acc;

    plvd_step u_step (
        .cur         (state_reg),
        .data_byte   (s1_byte_reg),
        .signed_mode (signed_mode_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    // the held byte moves on unless it would need a result slot that is blocked
    assign s1_take  = s1_valid_reg && (!step_res.emit || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_take;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            state_reg       <= '{PH_IDLE, 8'd0, 64'd0, 1'b0};
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                signed_mode_reg <= cfg_wdata;
            end
            s1_valid_reg <= s1_valid_next;
            if (s1_take)
            begin
                state_reg <= state_next;
            end
            if (s1_take && step_res.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg <= data_byte;
        end
        if (s1_take && step_res.emit)
        begin
            value_reg  <= step_res.value;
            status_reg <= step_res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PAYLOAD |->
            (state_reg.length_count != 8'd0 &&
             state_reg.length_count <= 8'(MAX_VALUE_BYTES)))
        else $error("payload phase with bad length");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |->
            (state_reg.length_count == 8'd0 && state_reg.accumulator == 64'd0 &&
             !state_reg.sign_flag))
        else $error("idle with leftover state");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg |-> value_reg == 64'd0)
        else $error("overflow result with nonzero value");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("held byte lost while stalled");

endmodule

>>> src/plvd_step.sv
module plvd_step
    import plvd_pkg::*;
(
    input  dec_state_t  cur,
    input  logic [7:0]  data_byte,
    input  logic        signed_mode,
    output dec_state_t  nxt,
    output dec_result_t res
);

    logic [7:0]  byte_q;
    logic [63:0] shifted;
    logic [7:0]  len_dec;
    logic        prefix_req;
    logic [7:0]  prefix_base;
    logic        sign_new;
    logic        dec_req;
    logic [7:0]  dec_len;
    logic [63:0] dec_acc;
    logic        fin_req;
    logic [63:0] fin_acc;
    logic        err_req;
    logic [3:0]  ones;

    assign byte_q = data_byte;

    always_comb
    begin
        shifted     = {cur.accumulator[55:0], byte_q};
        len_dec     = cur.length_count - 8'd1;
        prefix_req  = 1'b0;
        prefix_base = cur.length_count;
        sign_new    = cur.sign_flag;
        dec_req     = 1'b0;
        dec_len     = 8'd0;
        dec_acc     = 64'd0;
        fin_req     = 1'b0;
        fin_acc     = 64'd0;
        err_req     = 1'b0;
        ones        = 4'd0;
        nxt         = cur;
        res         = '0;

        case (cur.phase)
            PH_PAYLOAD:
            begin
                if (len_dec == 8'd0)
                begin
                    fin_req = 1'b1;
                    fin_acc = shifted;
                end
                else
                begin
                    nxt.accumulator  = shifted;
                    nxt.length_count = len_dec;
                end
            end
            PH_PREFIX:
            begin
                prefix_req = 1'b1;
            end
            default:
            begin
                if (signed_mode)
                begin
                    sign_new = byte_q[7];
                    if (byte_q[6:0] == SIGNED_PREFIX_BITS)
                    begin
                        nxt.phase        = PH_PREFIX;
                        nxt.length_count = 8'd7;
                        nxt.accumulator  = 64'd0;
                        nxt.sign_flag    = sign_new;
                    end
                    else
                    begin
                        ones    = lead_ones7(byte_q[6:0]);
                        dec_req = 1'b1;
                        dec_len = {4'd0, ones};
                        dec_acc = {57'd0, byte_q[6:0] & (7'h7f >> ones)};
                    end
                end
                else
                begin
                    sign_new    = 1'b0;
                    prefix_req  = 1'b1;
                    prefix_base = 8'd0;
                end
            end
        endcase

        if (prefix_req)
        begin
            if (byte_q == PREFIX_BYTE)
            begin
                nxt.phase        = PH_PREFIX;
                nxt.length_count = sat_add8(prefix_base, 4'd8);
                nxt.accumulator  = 64'd0;
                nxt.sign_flag    = sign_new;
            end
            else
            begin
                ones    = lead_ones8(byte_q);
                dec_req = 1'b1;
                dec_len = sat_add8(prefix_base, ones);
                dec_acc = {56'd0, byte_q & (8'hff >> ones)};
            end
        end

        if (dec_req)
        begin
            if (dec_len == 8'd0)
            begin
                fin_req = 1'b1;
                fin_acc = dec_acc;
            end
            else if (dec_len > 8'(MAX_VALUE_BYTES) ||
                     (dec_len == 8'(MAX_VALUE_BYTES) && dec_acc != 64'd0))
            begin
                err_req = 1'b1;
            end
            else
            begin
                nxt.phase        = PH_PAYLOAD;
                nxt.length_count = dec_len;
                nxt.accumulator  = dec_acc;
                nxt.sign_flag    = sign_new;
            end
        end

        // in signed mode, a magnitude above the signed limit is an overflow
        if (fin_req)
        begin
            if (signed_mode && fin_acc[63])
            begin
                err_req = 1'b1;
            end
            else
            begin
                res.emit   = 1'b1;
                res.status = 1'b0;
                res.value  = (signed_mode && sign_new) ? (~fin_acc + 64'd1) : fin_acc;
                nxt        = '{PH_IDLE, 8'd0, 64'd0, 1'b0};
            end
        end

        if (err_req)
        begin
            res.emit   = 1'b1;
            res.status = 1'b1;
            res.value  = 64'd0;
            nxt        = '{PH_IDLE, 8'd0, 64'd0, 1'b0};
        end
    end

endmodule

>>> dv/plvd_checker.sv
`timescale 1ns / 100ps

module plvd_checker
    import plvd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] value,
    input  logic        status,
    output int          fail_count,
    output int          open_results,
    output logic        item_open
);

    localparam logic [63:0] SIGNED_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [7:0]  LEN_LIMIT  = 8'(MAX_VALUE_BYTES);

    typedef struct packed {
        logic [63:0] word;
        logic        err;
    } decoded_t;

    decoded_t    decoded_q[$];
    phase_t      dec_phase;
    logic [7:0]  len_cnt;
    logic [63:0] acc;
    logic        neg;
    logic        signed_dec;

    function automatic int ones_from(input logic [7:0] b, input int top);
        int n;
        n = 0;
        for (int k = top; k >= 0; k--)
        begin
            if (!b[k])
                break;
            n++;
        end
        return n;
    endfunction

    function automatic logic [7:0] len_plus(input logic [7:0] a, input int n);
        int s;
        s = int'(a) + n;
        return (s > 255) ? 8'hff : 8'(s);
    endfunction

    function automatic void clear_item();
        dec_phase = PH_IDLE;
        len_cnt   = 8'd0;
        acc       = 64'd0;
        neg       = 1'b0;
    endfunction

    function automatic void push_overflow();
        clear_item();
        decoded_q.push_back('{word: 64'd0, err: 1'b1});
    endfunction

    function automatic void finish_value();
        logic [63:0] v;
        v = acc;
        if (signed_dec && v > SIGNED_MAX)
            push_overflow();
        else
        begin
            if (signed_dec && neg)
                v = ~v + 64'd1;
            clear_item();
            decoded_q.push_back('{word: v, err: 1'b0});
        end
    endfunction

    function automatic void close_prefix();
        if (len_cnt == 8'd0)
            finish_value();
        else if (len_cnt > LEN_LIMIT || (len_cnt == LEN_LIMIT && acc != 64'd0))
            push_overflow();
        else
            dec_phase = PH_PAYLOAD;
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        int ones;
        if (dec_phase == PH_PAYLOAD)
        begin
            acc     = {acc[55:0], b};
            len_cnt = len_cnt - 8'd1;
            if (len_cnt == 8'd0)
                finish_value();
        end
        else if (dec_phase != PH_PREFIX && signed_dec)
        begin
            neg = b[7];
            if (b[6:0] == SIGNED_PREFIX_BITS)
            begin
                // all-ones low bits: 7 so far, unsigned-style prefix follows
                len_cnt   = 8'd7;
                acc       = 64'd0;
                dec_phase = PH_PREFIX;
            end
            else
            begin
                ones    = ones_from(b, 6);
                len_cnt = 8'(ones);
                acc     = {57'd0, b[6:0] & (7'h7f >> ones)};
                close_prefix();
            end
        end
        else
        begin
            if (dec_phase != PH_PREFIX)
            begin
                len_cnt   = 8'd0;
                acc       = 64'd0;
                neg       = 1'b0;
                dec_phase = PH_PREFIX;
            end
            if (b == PREFIX_BYTE)
                len_cnt = len_plus(len_cnt, 8);
            else
            begin
                ones    = ones_from(b, 7);
                len_cnt = len_plus(len_cnt, ones);
                acc     = {56'd0, b & (8'hff >> ones)};
                close_prefix();
            end
        end
    endfunction

    function automatic void check_result();
        decoded_t want;
        if (decoded_q.size() == 0)
        begin
            fail_count++;
            $error("unexpected result: value %h status %0d", value, status);
        end
        else
        begin
            want = decoded_q.pop_front();
            if (value !== want.word)
            begin
                fail_count++;
                $error("value mismatch: expected %h actual %h", want.word, value);
            end
            if (status !== want.err)
            begin
                fail_count++;
                $error("status mismatch: expected %0d actual %0d", want.err, status);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_q.delete();
            clear_item();
            signed_dec   = 1'b0;
            fail_count   = 0;
            open_results <= 0;
            item_open    <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                take_byte(data_byte);
            if (cfg_we)
                signed_dec = cfg_wdata;
            open_results <= decoded_q.size();
            item_open    <= (dec_phase != PH_IDLE);
        end
    end

endmodule

>>> dv/prefix_length_varint_decoder_tb.sv
`timescale 1ns / 100ps

module prefix_length_varint_decoder_tb;
    import plvd_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic        status;

    int          fail_count;
    int          open_results;
    logic        item_open;
    logic        idle_en;
    logic        cur_mode;
    int          bytes_sent = 0;
    int          cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    prefix_length_varint_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status)
    );

    plvd_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .status       (status),
        .fail_count   (fail_count),
        .open_results (open_results),
        .item_open    (item_open)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side backpressure in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_payload(input int n, input logic keep_in_range);
        logic [7:0] b;
        for (int k = 0; k < n; k++)
        begin
            b = pick_byte();
            // mostly keep an 8-byte signed magnitude legal
            if (k == 0 && keep_in_range && $urandom_range(0, 3) != 0)
                b[7] = 1'b0;
            send_byte(b);
        end
    endtask

    task automatic send_unsigned(input int len, input logic [7:0] head);
        if (len == 8)
        begin
            send_byte(PREFIX_BYTE);
            send_byte(8'h00);
        end
        else
            send_byte(8'((32'hff << (8 - len)) | (head & (8'h7f >> len))));
        send_payload(len, 1'b0);
    endtask

    task automatic send_signed(input int len, input logic neg, input logic [7:0] head);
        if (len >= 7)
        begin
            send_byte({neg, SIGNED_PREFIX_BITS});
            send_byte(len == 8 ? 8'h80 : {1'b0, head[6:0]});
        end
        else
            send_byte({neg, 7'((32'h7f << (7 - len)) | (head & (8'h3f >> len)))});
        send_payload(len, len == 8);
    endtask

    task automatic random_item();
        int n;
        case ($urandom_range(0, 9))
            0:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom));
            end
            1:
            begin
                // long prefix runs, enough to saturate the length counter
                n = $urandom_range(1, 40);
                repeat (n) send_byte(PREFIX_BYTE);
                send_byte(8'($urandom));
            end
            default:
            begin
                n = $urandom_range(0, 8);
                if (cur_mode)
                    send_signed(n, 1'($urandom), 8'($urandom));
                else
                    send_unsigned(n, 8'($urandom));
            end
        endcase
    endtask

    // close any open item with zero bytes, then wait out every result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (item_open)
        begin
            send_byte(8'h00);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (open_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = mode;
    endtask

    task automatic run_phase(input logic mode, input int n);
        int stop;
        drain();
        write_mode(mode);
        stop = bytes_sent + n;
        while (bytes_sent < stop)
            random_item();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        idle_en   = 1'b1;
        cur_mode  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unsigned after reset: zero, one-byte max, short payload, 64-bit max
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(PREFIX_BYTE);
        send_byte(8'h00);
        repeat (8) send_byte(8'hff);
        // length 8 with head bits, length 9
        send_byte(PREFIX_BYTE);
        send_byte(8'h01);
        send_byte(PREFIX_BYTE);
        send_byte(8'h80);

        // signed: negative, negative zero, largest, one past largest
        drain();
        write_mode(1'b1);
        send_byte(8'hbf);
        send_byte(8'h80);
        send_byte(8'h7f);
        send_byte(8'h80);
        send_byte(8'h7f);
        repeat (7) send_byte(8'hff);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h80);
        repeat (7) send_byte(8'h00);

        run_phase(1'b0, 180);
        run_phase(1'b1, 180);
        run_phase(1'b0, 120);
        run_phase(1'b1, 120);
        idle_en = 1'b0;
        run_phase(1'b0, 100);
        drain();

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
src/plvd_pkg.sv
src/plvd_step.sv
src/prefix_length_varint_decoder.sv
dv/plvd_checker.sv
dv/prefix_length_varint_decoder_tb.sv
